@@ hw/rtl/flru_pkg.sv @@
// shared types and constants of the replacement order list
`default_nettype none

package flru_pkg;

	localparam int LIST_DEPTH_DEF    = 64;
	localparam int BLOCK_ID_BITS_DEF = 16;

	localparam int ACTION_W   = 2;
	localparam int BLOCK_ID_W = 16;
	localparam int STATUS_W   = 3;
	localparam int OCC_W      = 7;
	localparam int OCC_MAX    = 127;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_EVICT  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TOUCH  = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DUP    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd4;

	// controller to datapath
	typedef struct packed {
		logic                accept;
		logic                scan_start;
		logic                walk;
		logic                cmp;
		logic                move;
		logic                put_id;
		logic                append;
		logic                ev_rd;
		logic                ev_take;
		logic                load;
		logic [STATUS_W-1:0] status;
	} flru_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic hit;
		logic walk_end;
		logic out_busy;
	} flru_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/flru_if.sv @@
// request, response and configuration channel interfaces
`default_nettype none

interface flru_req_if;
	logic                              valid;
	logic                              ready;
	logic [flru_pkg::ACTION_W-1:0]     action;
	logic [flru_pkg::BLOCK_ID_W-1:0]   block_id;

	modport source (output valid, output action, output block_id, input ready);
	modport sink   (input valid, input action, input block_id, output ready);
endinterface

interface flru_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [flru_pkg::BLOCK_ID_W-1:0]   evicted_id;
	logic [flru_pkg::STATUS_W-1:0]     status;
	logic [flru_pkg::OCC_W-1:0]        occupancy;

	modport source (output valid, output evicted_id, output status, output occupancy,
		input ready);
	modport sink   (input valid, input evicted_id, input status, input occupancy,
		output ready);
endinterface

interface flru_cfg_if;
	logic valid;
	logic ready;
	logic policy_mode;

	modport source (output valid, output policy_mode, input ready);
	modport sink   (input valid, input policy_mode, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/fifo_lru_eviction_order_unit.sv @@
// top level of the lru / fifo replacement order list
//
// req carries one item: action (insert, evict, touch) and block_id. rsp returns
// one item per request: evicted_id, status and occupancy after the step. cfg
// writes policy_mode (0 fifo, 1 lru) and is always ready; write it only while idle.
// Blocks sit in a ring buffer memory with head pointer and count, so evict is a
// single read. Insert and touch walk the held entries through the one read port,
// one entry per cycle; touch then closes up the entries behind the hit and puts
// the block at the newest end.
// The result goes to the output register when the work ends; one item is worked at a time.
// A held result sits in the output register; a stalled receiver only delays the
// item that follows once its result is ready to be loaded.
// Reset empties the list and selects lru order; the memory itself is not cleared.
`default_nettype none

module fifo_lru_eviction_order_unit #(
	parameter int LIST_DEPTH    = flru_pkg::LIST_DEPTH_DEF,
	parameter int BLOCK_ID_BITS = flru_pkg::BLOCK_ID_BITS_DEF
) (
	input wire logic    clk,
	input wire logic    arst_n,
	flru_req_if.sink    req,
	flru_rsp_if.source  rsp,
	flru_cfg_if.sink    cfg
);
	import flru_pkg::*;

	flru_cmd_t cmd;
	flru_sts_t sts;

	flru_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req.valid),
		.req_ready   (req.ready),
		.action      (req.action),
		.cfg_valid   (cfg.valid),
		.cfg_ready   (cfg.ready),
		.policy_mode (cfg.policy_mode),
		.sts         (sts),
		.cmd         (cmd)
	);

	flru_dp #(
		.LIST_DEPTH    (LIST_DEPTH),
		.BLOCK_ID_BITS (BLOCK_ID_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.block_id   (req.block_id),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.evicted_id (rsp.evicted_id),
		.status     (rsp.status),
		.occupancy  (rsp.occupancy)
	);

	// one item at a time: no accept right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while previous item in progress");

	// an empty report means nothing is held
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_EMPTY)) |-> (rsp.occupancy == '0))
		else $error("empty status with nonzero occupancy");

	// a full report means the list is at its depth
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status == ST_FULL)) |->
		(32'(rsp.occupancy) == ((LIST_DEPTH > OCC_MAX) ? OCC_MAX : LIST_DEPTH)))
		else $error("full status with occupancy below depth");

	// a removed block only comes with an ok status
	a_evict_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.evicted_id != '0)) |-> (rsp.status == ST_OK))
		else $error("evicted block reported with error status");

endmodule

`default_nettype wire

@@ hw/rtl/flru_ctrl.sv @@
// sequencing state machine and policy register of the replacement order list
`default_nettype none

module flru_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire logic [flru_pkg::ACTION_W-1:0] action,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          policy_mode,
	input  wire flru_pkg::flru_sts_t           sts,
	output flru_pkg::flru_cmd_t                cmd
);
	import flru_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_SHIFT = 5'b00100,
		S_EVRD  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t              state_q, state_d;
	logic [ACTION_W-1:0] act_q, act_d;
	logic [STATUS_W-1:0] st_q, st_d;
	logic                mode_q;

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d    = state_q;
		act_d      = act_q;
		st_d       = st_q;
		cmd        = '0;
		cmd.status = st_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.accept = 1'b1;
					act_d      = action;
					st_d       = ST_OK;
					state_d    = S_DONE;
					case (action)
						ACT_INSERT: begin
							if (sts.full) begin
								st_d = ST_FULL;
							end else begin
								cmd.scan_start = 1'b1;
								state_d        = S_SCAN;
							end
						end
						ACT_EVICT: begin
							if (sts.empty) begin
								st_d = ST_EMPTY;
							end else begin
								cmd.ev_rd = 1'b1;
								state_d   = S_EVRD;
							end
						end
						ACT_TOUCH: begin
							// fifo mode leaves the order alone
							if (mode_q) begin
								cmd.scan_start = 1'b1;
								state_d        = S_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				cmd.walk = 1'b1;
				cmd.cmp  = 1'b1;
				if (sts.hit) begin
					if (act_q == ACT_TOUCH) begin
						state_d = S_SHIFT;
					end else begin
						st_d    = ST_DUP;
						state_d = S_DONE;
					end
				end else if (sts.walk_end) begin
					if (act_q == ACT_TOUCH) begin
						st_d = ST_ABSENT;
					end else begin
						cmd.append = 1'b1;
					end
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				cmd.walk = 1'b1;
				cmd.move = 1'b1;
				// entries behind the hit have closed up, touched block goes to the tail
				if (sts.walk_end) begin
					cmd.put_id = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_EVRD: begin
				cmd.ev_take = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q   <= ACT_INSERT;
			st_q    <= ST_OK;
			mode_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			act_q   <= act_d;
			st_q    <= st_d;
			if (cfg_valid) begin
				mode_q <= policy_mode;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/flru_dp.sv @@
// list memory, ring pointers, scan and shift walker, result register
`default_nettype none

module flru_dp #(
	parameter int LIST_DEPTH    = flru_pkg::LIST_DEPTH_DEF,
	parameter int BLOCK_ID_BITS = flru_pkg::BLOCK_ID_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire flru_pkg::flru_cmd_t             cmd,
	output flru_pkg::flru_sts_t                  sts,
	input  wire logic [flru_pkg::BLOCK_ID_W-1:0] block_id,
	input  wire logic                            rsp_ready,
	output logic                                 rsp_valid,
	output logic [flru_pkg::BLOCK_ID_W-1:0]      evicted_id,
	output logic [flru_pkg::STATUS_W-1:0]        status,
	output logic [flru_pkg::OCC_W-1:0]           occupancy
);
	import flru_pkg::*;

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int IW = BLOCK_ID_BITS;
	localparam logic [AW:0]   DEPTH_S = (AW+1)'(LIST_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(LIST_DEPTH - 1);

	function automatic logic [AW-1:0] inc_addr(input logic [AW-1:0] a);
		return (a == LAST_A) ? '0 : a + AW'(1);
	endfunction

	logic [IW-1:0]       mem [LIST_DEPTH];
	logic [IW-1:0]       rdata_q;
	logic [AW-1:0]       head_q;
	logic [CW-1:0]       cnt_q;
	logic [IW-1:0]       op_id_q;
	logic [IW-1:0]       ev_q;
	logic [AW-1:0]       ptr_q;
	logic [AW-1:0]       dst_q;
	logic [CW-1:0]       left_q;
	logic                pend_q;
	logic                out_vld_q;
	logic [BLOCK_ID_W-1:0] out_ev_q;
	logic [STATUS_W-1:0] out_st_q;
	logic [OCC_W-1:0]    out_occ_q;

	logic          hit;
	logic          walk_end;
	logic          issue;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [IW-1:0] wr_data;
	logic [AW:0]   tail_sum;
	logic [AW-1:0] tail;
	logic [OCC_W-1:0] occ;

	// read data lands in the cycle after issue, so compare and move work on pend_q
	assign hit      = pend_q && (rdata_q == op_id_q);
	assign walk_end = !pend_q && (left_q == '0);
	assign issue    = cmd.walk && (left_q != '0) && !(cmd.cmp && hit);

	assign tail_sum = (AW+1)'(head_q) + (AW+1)'(cnt_q);
	assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

	assign rd_en   = issue || cmd.ev_rd;
	assign rd_addr = cmd.ev_rd ? head_q : ptr_q;
	assign wr_en   = cmd.append || (cmd.move && pend_q) || cmd.put_id;
	assign wr_addr = cmd.append ? tail : dst_q;
	assign wr_data = (cmd.move && pend_q) ? rdata_q : op_id_q;

	assign occ = (32'(cnt_q) > 32'(OCC_MAX)) ? OCC_W'(OCC_MAX) : OCC_W'(cnt_q);

	assign sts.full     = (cnt_q == CW'(LIST_DEPTH));
	assign sts.empty    = (cnt_q == '0);
	assign sts.hit      = hit;
	assign sts.walk_end = walk_end;
	assign sts.out_busy = out_vld_q && !rsp_ready;

	assign rsp_valid  = out_vld_q;
	assign evicted_id = out_ev_q;
	assign status     = out_st_q;
	assign occupancy  = out_occ_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			cnt_q     <= '0;
			left_q    <= '0;
			pend_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			pend_q <= issue;
			if (cmd.scan_start) begin
				left_q <= cnt_q;
			end else if (issue) begin
				left_q <= left_q - CW'(1);
			end
			if (cmd.ev_rd) begin
				head_q <= inc_addr(head_q);
				cnt_q  <= cnt_q - CW'(1);
			end else if (cmd.append) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.load) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_id_q <= IW'(block_id);
			ev_q    <= '0;
		end else if (cmd.ev_take) begin
			ev_q <= rdata_q;
		end
		if (cmd.scan_start) begin
			ptr_q <= head_q;
		end else if (issue) begin
			ptr_q <= inc_addr(ptr_q);
		end
		// during the scan dst tracks the entry in flight; after a hit it is the write slot
		if (issue && cmd.cmp) begin
			dst_q <= ptr_q;
		end else if (cmd.move && pend_q) begin
			dst_q <= inc_addr(dst_q);
		end
		if (cmd.load) begin
			out_ev_q  <= BLOCK_ID_W'(ev_q);
			out_st_q  <= cmd.status;
			out_occ_q <= occ;
		end
	end

endmodule

`default_nettype wire
